@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker of this project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("concurrent assertion failed");

// Same check on the house clock and reset names.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/core/dsu_pkg.sv @@
// Package for the disjoint-set union-find unit: operation codes, widths,
// and the command and status types between controller and datapath.
// Depends on nothing.
package dsu_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int KIND_W     = 2;
  localparam int IDX_PORT_W = 10;
  localparam int CNT_PORT_W = 11;
  localparam int RANK_W     = 4;

  localparam logic [RANK_W-1:0]     RANK_MAX  = 4'd15;
  localparam logic [CNT_PORT_W-1:0] CNT_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND  = 2'd0,
    KIND_UNION = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_WALK_STEP,
    DP_COMP_START,
    DP_COMP_STEP,
    DP_TAKE_FIND,
    DP_TAKE_A,
    DP_LINK,
    DP_SWEEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;    // compression starts from the second element
    logic   set_err;  // index error flag captured with the item
    logic   init;     // sweep covers the whole table (reset pass)
  } dp_cmd_t;

  typedef struct packed {
    logic a_oob;
    logic b_oob;
    logic cnt_zero;
    logic at_root;
    logic comp_done;
    logic sweep_last;
  } dp_sts_t;

endpackage

@@ rtl/core/dsu_ctrl.sv @@
// Controller state machine of the union-find unit.
// Depends on dsu_pkg; drives dsu_dpath through dp_cmd_t and reads dp_sts_t.
module dsu_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [dsu_pkg::KIND_W-1:0]  kind_i,
  input  dsu_pkg::dp_sts_t            sts_i,
  output dsu_pkg::dp_cmd_t            cmd_o,
  output logic                        busy_o,
  output logic                        done_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_COMP  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       union_q, union_d;
  logic       phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      union_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      union_q <= union_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    union_d       = union_q;
    phase_d       = phase_q;
    cmd_o.op      = dsu_pkg::DP_NOP;
    cmd_o.sel_b   = 1'b0;
    cmd_o.set_err = 1'b0;
    cmd_o.init    = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op   = dsu_pkg::DP_SWEEP;
        cmd_o.init = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = dsu_pkg::DP_LATCH;
          phase_d  = 1'b0;
          union_d  = (kind_i == dsu_pkg::KIND_UNION);
          unique case (kind_i)
            dsu_pkg::KIND_FIND: begin
              cmd_o.set_err = sts_i.a_oob;
              state_d       = sts_i.a_oob ? S_DONE : S_WALK;
            end
            dsu_pkg::KIND_UNION: begin
              cmd_o.set_err = sts_i.a_oob || sts_i.b_oob;
              state_d       = (sts_i.a_oob || sts_i.b_oob) ? S_DONE : S_WALK;
            end
            dsu_pkg::KIND_CLEAR: begin
              state_d = sts_i.cnt_zero ? S_DONE : S_SWEEP;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (sts_i.at_root) begin
          cmd_o.op    = dsu_pkg::DP_COMP_START;
          cmd_o.sel_b = phase_q;
          state_d     = S_COMP;
        end else begin
          cmd_o.op = dsu_pkg::DP_WALK_STEP;
        end
      end
      S_COMP: begin
        if (!sts_i.comp_done) begin
          cmd_o.op = dsu_pkg::DP_COMP_STEP;
        end else if (!union_q) begin
          cmd_o.op = dsu_pkg::DP_TAKE_FIND;
          state_d  = S_DONE;
        end else if (!phase_q) begin
          cmd_o.op = dsu_pkg::DP_TAKE_A;
          phase_d  = 1'b1;
          state_d  = S_WALK;
        end else begin
          // Rank reads of both roots land during this cycle's edge.
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.op = dsu_pkg::DP_LINK;
        state_d  = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.op = dsu_pkg::DP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

@@ rtl/core/dsu_dpath.sv @@
// Datapath of the union-find unit: parent and rank memories, walk pointers,
// range checks, count register and result registers. Depends on dsu_pkg.
module dsu_dpath #(
  parameter int unsigned MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsu_pkg::CNT_PORT_W-1:0]  cfg_element_count_i,
  input  logic [dsu_pkg::IDX_PORT_W-1:0]  first_index_i,
  input  logic [dsu_pkg::IDX_PORT_W-1:0]  second_index_i,
  input  dsu_pkg::dp_cmd_t                cmd_i,
  output dsu_pkg::dp_sts_t                sts_o,
  output logic [dsu_pkg::IDX_PORT_W-1:0]  representative_o,
  output logic                            index_error_o
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (CNT_W > dsu_pkg::CNT_PORT_W) ? CNT_W : dsu_pkg::CNT_PORT_W;
  localparam int RW    = dsu_pkg::RANK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  logic [IDX_W-1:0] par_mem  [MAX_ELEMENTS];
  logic [RW-1:0]    rank_mem [MAX_ELEMENTS];

  logic [dsu_pkg::CNT_PORT_W-1:0] cnt_q;
  logic [CMP_W-1:0] cnt_ext, max_ext, act, a_ext, b_ext;
  logic [IDX_W-1:0] a_in, b_in, start_idx;

  logic [IDX_W-1:0] a_q, a_d, b_q, b_d, last_q, last_d;
  logic [IDX_W-1:0] cur_q, cur_d, root_q, root_d, ra_q, ra_d;
  logic [IDX_W-1:0] sw_q, sw_d, rep_q, rep_d;
  logic             err_q, err_d;
  logic [IDX_W-1:0] par_rd_q;
  logic [RW-1:0]    rka_q, rkb_q;

  logic             par_we, rank_we;
  logic [IDX_W-1:0] par_raddr, par_waddr, par_wdata, rank_waddr;
  logic [RW-1:0]    rank_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= dsu_pkg::CNT_RESET;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_element_count_i;
    end
  end

  // Count in use, limited to the table size.
  assign cnt_ext = CMP_W'(cnt_q);
  assign max_ext = CMP_W'(MAX_ELEMENTS);
  assign act     = (cnt_ext > max_ext) ? max_ext : cnt_ext;
  assign a_ext   = CMP_W'(first_index_i);
  assign b_ext   = CMP_W'(second_index_i);
  assign a_in    = IDX_W'(first_index_i);
  assign b_in    = IDX_W'(second_index_i);
  assign start_idx = cmd_i.sel_b ? b_q : a_q;

  assign sts_o.a_oob      = (a_ext >= act);
  assign sts_o.b_oob      = (b_ext >= act);
  assign sts_o.cnt_zero   = (act == '0);
  assign sts_o.at_root    = (par_rd_q == cur_q);
  assign sts_o.comp_done  = (cur_q == root_q);
  assign sts_o.sweep_last = (sw_q == (cmd_i.init ? LAST_IDX : last_q));

  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    last_d     = last_q;
    cur_d      = cur_q;
    root_d     = root_q;
    ra_d       = ra_q;
    sw_d       = sw_q;
    rep_d      = rep_q;
    err_d      = err_q;
    par_raddr  = cur_q;
    par_we     = 1'b0;
    par_waddr  = cur_q;
    par_wdata  = root_q;
    rank_we    = 1'b0;
    rank_waddr = root_q;
    rank_wdata = '0;
    case (cmd_i.op)
      dsu_pkg::DP_LATCH: begin
        a_d       = a_in;
        b_d       = b_in;
        last_d    = IDX_W'(act - CMP_W'(1));
        err_d     = cmd_i.set_err;
        rep_d     = '0;
        cur_d     = a_in;
        par_raddr = a_in;
      end
      dsu_pkg::DP_WALK_STEP: begin
        cur_d     = par_rd_q;
        par_raddr = par_rd_q;
      end
      dsu_pkg::DP_COMP_START: begin
        root_d    = cur_q;
        cur_d     = start_idx;
        par_raddr = start_idx;
      end
      dsu_pkg::DP_COMP_STEP: begin
        // Point the visited entry at the root, step to its old parent and fetch that entry's parent.
        par_we    = 1'b1;
        par_waddr = cur_q;
        par_wdata = root_q;
        cur_d     = par_rd_q;
        par_raddr = par_rd_q;
      end
      dsu_pkg::DP_TAKE_FIND: begin
        rep_d = root_q;
      end
      dsu_pkg::DP_TAKE_A: begin
        ra_d      = root_q;
        cur_d     = b_q;
        par_raddr = b_q;
      end
      dsu_pkg::DP_LINK: begin
        if (ra_q == root_q) begin
          rep_d = ra_q;
        end else if (rka_q > rkb_q) begin
          par_we    = 1'b1;
          par_waddr = root_q;
          par_wdata = ra_q;
          rep_d     = ra_q;
        end else begin
          par_we    = 1'b1;
          par_waddr = ra_q;
          par_wdata = root_q;
          rep_d     = root_q;
          if ((rka_q == rkb_q) && (rkb_q != dsu_pkg::RANK_MAX)) begin
            rank_we    = 1'b1;
            rank_waddr = root_q;
            rank_wdata = rkb_q + RW'(1);
          end
        end
      end
      dsu_pkg::DP_SWEEP: begin
        par_we     = 1'b1;
        par_waddr  = sw_q;
        par_wdata  = sw_q;
        rank_we    = 1'b1;
        rank_waddr = sw_q;
        rank_wdata = '0;
        sw_d       = sts_o.sweep_last ? '0 : sw_q + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else begin
      sw_q <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    last_q <= last_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    ra_q   <= ra_d;
    rep_q  <= rep_d;
    err_q  <= err_d;
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd_q <= par_mem[par_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rka_q <= rank_mem[ra_q];
    rkb_q <= rank_mem[root_q];
  end

  assign representative_o = dsu_pkg::IDX_PORT_W'(rep_q);
  assign index_error_o    = err_q;

endmodule

@@ rtl/core/disjoint_set_union_find_unit.sv @@
// Top level of the disjoint-set union-find unit (union by rank, path
// compression). Depends on dsu_pkg, dsu_ctrl and dsu_dpath.
//
//  Channel   | Handshake                      | Payload
//  ----------+--------------------------------+-------------------------------------
//  command   | start in, busy out             | kind_i, first_index_i, second_index_i
//  result    | done_o strobe, one cycle       | representative_o, index_error_o
//  config    | cfg_valid_i in, cfg_ready_o out| cfg_element_count_i
//
// A command transfer takes place at a rising edge with start high and busy low.
// A find walks from the first element to its root, then compresses that path; a union does
// this for both elements, then links the roots by rank. Each link is walked and compressed on
// the single parent read port. Ranks keep paths near log2 of the count unless a count change
// left links. A clear sweeps the entries in use; index errors and the spare code skip to done.
// After reset busy stays high while all MAX_ELEMENTS entries are swept, one per cycle.
// The result strobe cannot be stalled: the receiver must take it when shown.
module disjoint_set_union_find_unit #(
  parameter int unsigned MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [dsu_pkg::KIND_W-1:0]      kind_i,
  input  logic [dsu_pkg::IDX_PORT_W-1:0]  first_index_i,
  input  logic [dsu_pkg::IDX_PORT_W-1:0]  second_index_i,
  output logic                            done_o,
  output logic [dsu_pkg::IDX_PORT_W-1:0]  representative_o,
  output logic                            index_error_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dsu_pkg::CNT_PORT_W-1:0]  cfg_element_count_i
);

  dsu_pkg::dp_cmd_t cmd;
  dsu_pkg::dp_sts_t sts;

  // The count register is always free to take a transfer; the count is only
  // looked at when a command is accepted or a clear sweep starts.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the root walk, the compression write-back, the
  // rank compare of a union and the clearing sweeps.
  dsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // The datapath owns both memories and all pointer and result registers.
  dsu_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_element_count_i (cfg_element_count_i),
    .first_index_i       (first_index_i),
    .second_index_i      (second_index_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .representative_o    (representative_o),
    .index_error_o       (index_error_o)
  );

endmodule

@@ rtl/core/dsu_checker.sv @@
// Port-level checker for the union-find unit, bound to the top level.
// Depends on dsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsu_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [dsu_pkg::KIND_W-1:0]  kind_i,
  input logic                        done_o,
  input logic [dsu_pkg::IDX_PORT_W-1:0] representative_o,
  input logic                        index_error_o
);

  logic spare_cmd;
  logic empty_res;

  // A command with the unused code, and a result that carries nothing.
  assign spare_cmd = start && !busy && (kind_i != dsu_pkg::KIND_FIND) &&
                     (kind_i != dsu_pkg::KIND_UNION) && (kind_i != dsu_pkg::KIND_CLEAR);
  assign empty_res = done_o && !index_error_o && (representative_o == '0);

  `ASSERT_DEF(a_done_single, done_o |=> !done_o)
  `ASSERT_DEF(a_done_busy, done_o |-> busy)
  `ASSERT_DEF(a_accept_busy, (start && !busy) |=> busy)
  `ASSERT_DEF(a_err_zero, (done_o && index_error_o) |-> (representative_o == '0))
  `ASSERT_DEF(a_unused_kind, spare_cmd |=> empty_res)

endmodule

bind disjoint_set_union_find_unit dsu_port_checker u_dsu_port_checker (.*);
